// ===== rtl/erdc_pkg.sv =====
// Shared types, constants and helper functions for the edge reference duplicate checker.
// No dependencies; every other file refers to this package by scoped names.
package erdc_pkg;

  // Table depth and derived widths
  localparam int MAX_EDGES = 64;
  localparam int IDX_W     = $clog2(MAX_EDGES);
  localparam int CNT_W     = 16;
  localparam logic [CNT_W-1:0] COUNT_CAP = {CNT_W{1'b1}};
  localparam int OUT_NUM_W = 7;
  localparam logic [OUT_NUM_W-1:0] OUT_CAP = {OUT_NUM_W{1'b1}};

  localparam int LEN_TOL_W = 21;
  localparam int ANG_TOL_W = 31;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DAT_W = 31;

  localparam logic [CFG_IDX_W-1:0] CFG_LEN_TOL = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_ANG_TOL = 1'b1;

  localparam logic [LEN_TOL_W-1:0] LEN_TOL_RESET = 21'd1000;
  localparam logic [ANG_TOL_W-1:0] ANG_TOL_RESET = 31'd1074;

  localparam logic signed [31:0] NONFINITE = 32'sh8000_0000;
  localparam logic signed [31:0] DIR_ONE   = 32'sh4000_0000;
  localparam logic [31:0]        MAG_CAP   = 32'h8000_0000;

  localparam logic [1:0] KIND_LINE   = 2'd0;
  localparam logic [1:0] KIND_CIRCLE = 2'd1;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_BAD_KIND   = 3'd1,
    ST_NONFINITE  = 3'd2,
    ST_BAD_RADIUS = 3'd3,
    ST_DUPLICATE  = 3'd4,
    ST_SKIPPED    = 3'd5,
    ST_TABLE_FULL = 3'd6
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_SCAN,
    S_DRAIN,
    S_DONE
  } ctrl_state_t;

  typedef struct packed {
    logic [1:0]         curve_kind;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
    logic signed [31:0] dir_x;
    logic signed [31:0] dir_y;
    logic signed [31:0] dir_z;
    logic signed [31:0] circle_radius;
    logic               last_edge;
  } in_item_t;

  typedef struct packed {
    logic [2:0]           status;
    logic [OUT_NUM_W-1:0] edge_number;
    logic [OUT_NUM_W-1:0] match_number;
    logic                 selection_ok;
    logic                 last_result;
  } out_item_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] pz;
    logic signed [31:0] dx;
    logic signed [31:0] dy;
    logic signed [31:0] dz;
    logic signed [31:0] rad;
  } entry_t;

  // Controller to datapath
  typedef struct packed {
    logic             capture;
    logic             issue;
    logic [IDX_W-1:0] issue_idx;
    logic             finish;
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic           pre_ok;
    logic [IDX_W:0] scan_end;
    logic           busy;
    logic           hit;
    logic           out_free;
  } dp_stat_t;

  // Saturate a direction component to plus or minus one
  function automatic logic signed [31:0] clamp_dir(input logic signed [31:0] d);
    logic signed [31:0] r;
    r = d;
    if (d > DIR_ONE) r = DIR_ONE;
    if (d < -DIR_ONE) r = -DIR_ONE;
    return r;
  endfunction

  // Magnitude, rounded half up after dropping sh bits, clamped to 2^31
  function automatic logic [31:0] mag_round(input logic signed [63:0] c, input int sh);
    logic [63:0] m;
    logic [63:0] r;
    m = c[63] ? 64'(-c) : 64'(c);
    r = (m + (64'd1 << (sh - 1))) >> sh;
    return (r > 64'(MAG_CAP)) ? MAG_CAP : r[31:0];
  endfunction

  // Magnitude of a 33-bit difference, clamped to 2^31
  function automatic logic [31:0] mag_clamp(input logic signed [32:0] c);
    logic [32:0] m;
    m = c[32] ? 33'(-c) : 33'(c);
    return (m > 33'(MAG_CAP)) ? MAG_CAP : m[31:0];
  endfunction

endpackage

// ===== rtl/erdc_ctrl.sv =====
// Sequencer for the duplicate checker: capture, validation, table scan, drain, result.
// Depends on erdc_pkg for the state, command and status types.
module erdc_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  output erdc_pkg::ctrl_cmd_t cmd,
  input  erdc_pkg::dp_stat_t  stat
);

  erdc_pkg::ctrl_state_t state_r, state_nxt;
  logic [erdc_pkg::IDX_W:0] scan_r, scan_nxt;

  // State and scan pointer registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= erdc_pkg::S_IDLE;
      scan_r  <= '0;
    end else begin
      state_r <= state_nxt;
      scan_r  <= scan_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt     = state_r;
    scan_nxt      = scan_r;
    cmd.capture   = 1'b0;
    cmd.issue     = 1'b0;
    cmd.issue_idx = scan_r[erdc_pkg::IDX_W-1:0];
    cmd.finish    = 1'b0;
    in_stall      = 1'b1;
    case (state_r)
      erdc_pkg::S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = erdc_pkg::S_CHECK;
        end
      end
      erdc_pkg::S_CHECK: begin
        scan_nxt = '0;
        if (stat.pre_ok && stat.scan_end != '0) state_nxt = erdc_pkg::S_SCAN;
        else state_nxt = erdc_pkg::S_DONE;
      end
      erdc_pkg::S_SCAN: begin
        // stop issuing once a match has come back
        if (stat.hit) begin
          state_nxt = erdc_pkg::S_DRAIN;
        end else begin
          cmd.issue = 1'b1;
          scan_nxt  = scan_r + 1'b1;
          if (scan_nxt == stat.scan_end) state_nxt = erdc_pkg::S_DRAIN;
        end
      end
      erdc_pkg::S_DRAIN: begin
        if (!stat.busy) state_nxt = erdc_pkg::S_DONE;
      end
      erdc_pkg::S_DONE: begin
        if (stat.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = erdc_pkg::S_IDLE;
        end
      end
      default: state_nxt = erdc_pkg::S_IDLE;
    endcase
  end

endmodule

// ===== rtl/erdc_dp.sv =====
// Datapath of the duplicate checker: tolerances, edge table, compare pipeline, result register.
// Depends on erdc_pkg; driven by erdc_ctrl through command and status structs.
module erdc_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  erdc_pkg::in_item_t            in_data,
  input  logic                          cfg_valid,
  input  logic [erdc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [erdc_pkg::CFG_DAT_W-1:0] cfg_data,
  input  erdc_pkg::ctrl_cmd_t           cmd,
  output erdc_pkg::dp_stat_t            stat,
  output logic                          out_valid,
  input  logic                          out_stall,
  output erdc_pkg::out_item_t           out_data
);

  localparam int IDX_W = erdc_pkg::IDX_W;
  localparam int CNT_W = erdc_pkg::CNT_W;

  // Configuration
  logic [erdc_pkg::LEN_TOL_W-1:0] len_tol_r;
  logic [erdc_pkg::ANG_TOL_W-1:0] ang_tol_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_tol_r <= erdc_pkg::LEN_TOL_RESET;
      ang_tol_r <= erdc_pkg::ANG_TOL_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        erdc_pkg::CFG_LEN_TOL: len_tol_r <= cfg_data[erdc_pkg::LEN_TOL_W-1:0];
        erdc_pkg::CFG_ANG_TOL: ang_tol_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Selection state
  logic [CNT_W-1:0] count_r;
  logic             err_r;
  logic [CNT_W-1:0] num_r, num_nxt, stored_r;
  erdc_pkg::entry_t cur_r;
  logic             last_r;
  erdc_pkg::status_t pre_r, pre_nxt;
  logic [41:0]      len_sq_r;
  logic [61:0]      ang_sq_r;

  assign num_nxt = (count_r == erdc_pkg::COUNT_CAP) ? count_r : count_r + 1'b1;

  // Validate the incoming edge ahead of the scan
  always_comb begin
    if (err_r) pre_nxt = erdc_pkg::ST_SKIPPED;
    else if (in_data.curve_kind != erdc_pkg::KIND_LINE &&
             in_data.curve_kind != erdc_pkg::KIND_CIRCLE) pre_nxt = erdc_pkg::ST_BAD_KIND;
    else if (in_data.point_x == erdc_pkg::NONFINITE || in_data.point_y == erdc_pkg::NONFINITE
             || in_data.point_z == erdc_pkg::NONFINITE) pre_nxt = erdc_pkg::ST_NONFINITE;
    else if (in_data.curve_kind == erdc_pkg::KIND_CIRCLE &&
             (in_data.circle_radius == erdc_pkg::NONFINITE ||
              $signed({in_data.circle_radius[31], in_data.circle_radius}) <=
              $signed({12'd0, len_tol_r}))) pre_nxt = erdc_pkg::ST_BAD_RADIUS;
    else pre_nxt = erdc_pkg::ST_OK;
  end

  // Capture the item and the squared tolerances
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cur_r.kind <= in_data.curve_kind;
      cur_r.px   <= in_data.point_x;
      cur_r.py   <= in_data.point_y;
      cur_r.pz   <= in_data.point_z;
      cur_r.dx   <= erdc_pkg::clamp_dir(in_data.dir_x);
      cur_r.dy   <= erdc_pkg::clamp_dir(in_data.dir_y);
      cur_r.dz   <= erdc_pkg::clamp_dir(in_data.dir_z);
      cur_r.rad  <= in_data.circle_radius;
      last_r     <= in_data.last_edge;
      pre_r      <= pre_nxt;
      num_r      <= num_nxt;
      stored_r   <= num_nxt - 1'b1;
      len_sq_r   <= 42'(len_tol_r) * 42'(len_tol_r);
      ang_sq_r   <= 62'(ang_tol_r) * 62'(ang_tol_r);
    end
  end

  logic table_full;
  assign table_full = (stored_r >= CNT_W'(erdc_pkg::MAX_EDGES));

  // Edge table
  erdc_pkg::entry_t mem [erdc_pkg::MAX_EDGES];
  erdc_pkg::entry_t rd_r;
  logic             v0_r;
  logic [IDX_W-1:0] i0_r;
  logic             hit_r;
  logic [IDX_W-1:0] hit_idx_r;
  erdc_pkg::status_t fin_status;
  logic             err_nxt;

  always_comb begin
    if (pre_r != erdc_pkg::ST_OK) fin_status = pre_r;
    else if (hit_r) fin_status = erdc_pkg::ST_DUPLICATE;
    else if (table_full) fin_status = erdc_pkg::ST_TABLE_FULL;
    else fin_status = erdc_pkg::ST_OK;
  end

  assign err_nxt = err_r || (fin_status != erdc_pkg::ST_OK &&
                             fin_status != erdc_pkg::ST_SKIPPED);

  always_ff @(posedge clk) begin
    if (cmd.finish && fin_status == erdc_pkg::ST_OK)
      mem[stored_r[IDX_W-1:0]] <= cur_r;
    if (cmd.issue) rd_r <= mem[cmd.issue_idx];
  end

  // Compare pipeline: differences, products, cross terms, squares, compare
  logic             v1_r, v2_r, v3_r, v4_r;
  logic [IDX_W-1:0] i1_r, i2_r, i3_r, i4_r;
  logic             ke1_r, ke2_r, ke3_r, ke4_r;
  logic signed [32:0] ex1_r, ey1_r, ez1_r, rd1_r;
  logic signed [31:0] bx1_r, by1_r, bz1_r;
  logic signed [63:0] pa_r, pb_r, pc_r, pd_r, pe_r, pf_r;
  logic signed [63:0] la_r, lb_r, lc_r, ld_r, le_r, lf_r;
  logic signed [32:0] ex2_r, ey2_r, ez2_r, rd2_r;
  logic [31:0]      dcx_r, dcy_r, dcz_r, lcx_r, lcy_r, lcz_r, ccx_r, ccy_r, ccz_r;
  logic [32:0]      rm3_r;
  logic [63:0]      dsx_r, dsy_r, dsz_r, lsx_r, lsy_r, lsz_r, csx_r, csy_r, csz_r;
  logic             rok4_r;
  logic [65:0]      dsum, lsum, csum;
  logic             match;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      v0_r <= cmd.issue;
      v1_r <= v0_r;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    i0_r <= cmd.issue_idx;
    // stage 1: differences against the stored entry
    i1_r  <= i0_r;
    ke1_r <= (rd_r.kind == cur_r.kind);
    ex1_r <= 33'(cur_r.px) - 33'(rd_r.px);
    ey1_r <= 33'(cur_r.py) - 33'(rd_r.py);
    ez1_r <= 33'(cur_r.pz) - 33'(rd_r.pz);
    rd1_r <= 33'(cur_r.rad) - 33'(rd_r.rad);
    bx1_r <= rd_r.dx;
    by1_r <= rd_r.dy;
    bz1_r <= rd_r.dz;
    // stage 2: products
    i2_r  <= i1_r;
    ke2_r <= ke1_r;
    pa_r  <= 64'(cur_r.dy) * 64'(bz1_r);
    pb_r  <= 64'(cur_r.dz) * 64'(by1_r);
    pc_r  <= 64'(cur_r.dz) * 64'(bx1_r);
    pd_r  <= 64'(cur_r.dx) * 64'(bz1_r);
    pe_r  <= 64'(cur_r.dx) * 64'(by1_r);
    pf_r  <= 64'(cur_r.dy) * 64'(bx1_r);
    la_r  <= 64'(ey1_r) * 64'(bz1_r);
    lb_r  <= 64'(ez1_r) * 64'(by1_r);
    lc_r  <= 64'(ez1_r) * 64'(bx1_r);
    ld_r  <= 64'(ex1_r) * 64'(bz1_r);
    le_r  <= 64'(ex1_r) * 64'(by1_r);
    lf_r  <= 64'(ey1_r) * 64'(bx1_r);
    ex2_r <= ex1_r;
    ey2_r <= ey1_r;
    ez2_r <= ez1_r;
    rd2_r <= rd1_r;
    // stage 3: cross components, rounded magnitudes
    i3_r  <= i2_r;
    ke3_r <= ke2_r;
    dcx_r <= erdc_pkg::mag_round(pa_r - pb_r, 30);
    dcy_r <= erdc_pkg::mag_round(pc_r - pd_r, 30);
    dcz_r <= erdc_pkg::mag_round(pe_r - pf_r, 30);
    lcx_r <= erdc_pkg::mag_round(la_r - lb_r, 20);
    lcy_r <= erdc_pkg::mag_round(lc_r - ld_r, 20);
    lcz_r <= erdc_pkg::mag_round(le_r - lf_r, 20);
    ccx_r <= erdc_pkg::mag_clamp(ex2_r);
    ccy_r <= erdc_pkg::mag_clamp(ey2_r);
    ccz_r <= erdc_pkg::mag_clamp(ez2_r);
    rm3_r <= rd2_r[32] ? 33'(-rd2_r) : 33'(rd2_r);
    // stage 4: squares
    i4_r   <= i3_r;
    ke4_r  <= ke3_r;
    dsx_r  <= 64'(dcx_r) * 64'(dcx_r);
    dsy_r  <= 64'(dcy_r) * 64'(dcy_r);
    dsz_r  <= 64'(dcz_r) * 64'(dcz_r);
    lsx_r  <= 64'(lcx_r) * 64'(lcx_r);
    lsy_r  <= 64'(lcy_r) * 64'(lcy_r);
    lsz_r  <= 64'(lcz_r) * 64'(lcz_r);
    csx_r  <= 64'(ccx_r) * 64'(ccx_r);
    csy_r  <= 64'(ccy_r) * 64'(ccy_r);
    csz_r  <= 64'(ccz_r) * 64'(ccz_r);
    rok4_r <= (rm3_r <= 33'(len_tol_r));
  end

  // Final sums and tolerance compares
  assign dsum = 66'(dsx_r) + 66'(dsy_r) + 66'(dsz_r);
  assign lsum = 66'(lsx_r) + 66'(lsy_r) + 66'(lsz_r);
  assign csum = 66'(csx_r) + 66'(csy_r) + 66'(csz_r);

  always_comb begin
    match = ke4_r && (dsum <= 66'(ang_sq_r));
    if (cur_r.kind == erdc_pkg::KIND_LINE) match = match && (lsum <= (66'(len_sq_r) << 20));
    else match = match && (csum <= 66'(len_sq_r)) && rok4_r;
  end

  // Keep the first match of the scan
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_r <= 1'b0;
    end else if (cmd.capture) begin
      hit_r <= 1'b0;
    end else if (v4_r && match && !hit_r) begin
      hit_r     <= 1'b1;
      hit_idx_r <= i4_r;
    end
  end

  // Output register and selection bookkeeping
  logic      out_valid_r;
  erdc_pkg::out_item_t out_r;
  logic [IDX_W:0] match_num;

  assign match_num = {1'b0, hit_idx_r} + 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      count_r     <= '0;
      err_r       <= 1'b0;
    end else begin
      if (cmd.finish) begin
        out_valid_r <= 1'b1;
        count_r     <= last_r ? '0 : num_r;
        err_r       <= last_r ? 1'b0 : err_nxt;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_r.status       <= fin_status;
      out_r.edge_number  <= (num_r > CNT_W'(erdc_pkg::OUT_CAP)) ? erdc_pkg::OUT_CAP :
                            num_r[erdc_pkg::OUT_NUM_W-1:0];
      out_r.match_number <= (fin_status != erdc_pkg::ST_DUPLICATE) ? '0 :
                            ((32'(match_num) > 32'(erdc_pkg::OUT_CAP)) ? erdc_pkg::OUT_CAP :
                             erdc_pkg::OUT_NUM_W'(match_num));
      out_r.selection_ok <= !err_nxt;
      out_r.last_result  <= last_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Status back to the controller
  assign stat.pre_ok   = (pre_r == erdc_pkg::ST_OK);
  assign stat.scan_end = table_full ? (IDX_W+1)'(erdc_pkg::MAX_EDGES) : stored_r[IDX_W:0];
  assign stat.busy     = v0_r | v1_r | v2_r | v3_r | v4_r;
  assign stat.hit      = hit_r;
  assign stat.out_free = !out_valid_r || !out_stall;

endmodule

// ===== rtl/edge_reference_duplicate_checker.sv =====
// Edge reference duplicate checker: top level joining the controller and the datapath.
// Depends on erdc_pkg, erdc_ctrl and erdc_dp.
//
// Usage: one edge reference is transferred on the in_ channel when in_valid is high and
// in_stall is low; in_stall is low only while the block is idle. Each edge gives exactly
// one result on the out_ channel, transferred when out_valid is high and out_stall low.
// The cfg_ channel writes length_tolerance (index 0) and angular_tolerance (index 1);
// cfg_ready is always high, and writes belong to idle periods.
// Sequence: an edge that fails validation, or the first of a selection, goes from capture
// through the check state straight to the result. An edge that is scanned is compared with
// the stored edges, one per cycle, through a compare pipeline fed by the table read
// port (differences, products, cross terms, squares); the scan stops early on the first
// match. A result waiting in the output register does not block the next transfer; a
// stalled receiver holds the next result in the final state.
// Reset (rst_n low, synchronous) clears the edge count, the error flag, the pipeline and
// the output valid, and restores the tolerance defaults. The edge table needs no clearing.
module edge_reference_duplicate_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  erdc_pkg::in_item_t             in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output erdc_pkg::out_item_t            out_data,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [erdc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [erdc_pkg::CFG_DAT_W-1:0] cfg_data
);

  erdc_pkg::ctrl_cmd_t cmd;
  erdc_pkg::dp_stat_t  stat;

  assign cfg_ready = 1'b1;

  erdc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .cmd      (cmd),
    .stat     (stat)
  );

  erdc_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_valid (cfg_valid & cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
